// File: rtl/rpn_expression_evaluator_defines.svh
// Assertion macros for the postfix evaluator
`ifndef RPN_EXPRESSION_EVALUATOR_DEFINES_SVH
`define RPN_EXPRESSION_EVALUATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RPN_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rpn check failed");
`define RPN_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rpn check failed");
`else
`define RPN_ASSERT_IMP(label, clk, rst_n, a, c)
`define RPN_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/rpn_pkg.sv
// Package: types, constants and codes of the postfix evaluator
`default_nettype none
package rpn_pkg;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned SpW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned MaxNumberChars = 10;
  localparam int unsigned NcW = 5;
  localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegMax = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DIV0 = 3'd1, ST_LONG = 3'd2, ST_UNDER = 3'd3, ST_OVER = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2, OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CONV_DIV, S_CONV_PUSH, S_OP_RD1, S_OP_RD2, S_OP_WAIT,
    S_OP_START, S_OP_RUN, S_OP_PUSH, S_END_RD, S_END_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [1:0] mode;
  } unit_ctl_t;

  localparam logic [1:0] MODE_DIV = 2'd0;
  localparam logic [1:0] MODE_MUL = 2'd1;

  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd0: p = 64'd1;
      5'd1: p = 64'd10;
      5'd2: p = 64'd100;
      5'd3: p = 64'd1000;
      5'd4: p = 64'd10000;
      5'd5: p = 64'd100000;
      5'd6: p = 64'd1000000;
      5'd7: p = 64'd10000000;
      5'd8: p = 64'd100000000;
      5'd9: p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      default: p = 64'd10000000000000000;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

// File: rtl/rpn_if.sv
// Valid/ready channel interfaces for characters and results
`default_nettype none
interface rpn_char_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface rpn_result_if (input wire logic clk);
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [2:0]         status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

// File: rtl/rpn_expression_evaluator.sv
// Top level: postfix Q32.32 evaluator with operand stack and sequencer
// One character beat is taken per pass of the sequencer. Digits and points build the
// number; a character that closes a number starts a 96-step divide by the power of
// ten. That divide, * and / run through one shared bit-serial unit; + and - are
// combinational. End of text leads to the result beat, and input is held off until
// that beat is taken. The operand stack is a 32-entry memory with a registered
// read port.
`default_nettype none
`include "rpn_expression_evaluator_defines.svh"
module rpn_expression_evaluator
  import rpn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  rpn_char_if.sink     in_ch,
  rpn_result_if.source out_ch
);
  state_t      state_r, state_nxt;
  logic [7:0]  ch_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [63:0] mant_r, mant_nxt;
  logic [NcW-1:0] nchars_r, nchars_nxt;
  logic        point_r, point_nxt, second_r, second_nxt;
  logic [4:0]  fdig_r, fdig_nxt;
  status_t     err_r, err_nxt;
  logic [63:0] mem [StackDepth];
  logic [63:0] rd_r;
  logic [SpW-1:0] rd_addr;
  logic        wr_en;
  logic [SpW-1:0] wr_addr;
  logic [63:0] wr_data;
  logic [63:0] right_r, right_nxt, left_r, left_nxt;
  logic [63:0] whole_r, whole_nxt;
  logic        neg_r, neg_nxt;
  logic        is_digit, is_point, is_op, in_acc, out_acc;
  logic        ovalid_r, ovalid_nxt;
  logic [63:0] oval_r, oval_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  unit_ctl_t   uctl;
  logic [63:0] ua, ub;
  logic [95:0] uquo;
  logic        ubusy, udone;
  logic [63:0] ma, mb, res, sum, mag, frac;
  logic        over;
  logic [63:0] p10;

  rpn_unit u_unit (
    .clk(clk), .rst_n(rst_n), .ctl(uctl), .a_in(ua), .b_in(ub),
    .busy(ubusy), .done(udone), .quo(uquo)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.value = oval_r;
  assign out_ch.status = ostat_r;

  assign is_digit = in_ch.char_code >= ChZero && in_ch.char_code <= ChNine;
  assign is_point = in_ch.char_code == ChPoint;
  assign is_op = ch_r == ChPlus || ch_r == ChMinus || ch_r == ChStar || ch_r == ChSlash;
  assign p10 = pow10(fdig_r);
  assign ma = left_r[63] ? (~left_r + 64'd1) : left_r;
  assign mb = right_r[63] ? (~right_r + 64'd1) : right_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.char_code == 8'd0 || err_r == ST_OK) && !is_digit && !is_point)
          state_nxt = (nchars_r != '0 && err_r == ST_OK) ? S_CONV_DIV
                    : (in_ch.char_code == 8'd0) ? S_END_RD : S_OP_RD1;
      end
      S_CONV_DIV: if (udone) state_nxt = S_CONV_PUSH;
      S_CONV_PUSH: state_nxt = (ch_r == 8'd0) ? S_END_RD : S_OP_RD1;
      S_OP_RD1: state_nxt = (err_r != ST_OK && ch_r != 8'd0) ? S_IDLE
                          : (ch_r == 8'd0) ? S_END_RD : (!is_op) ? S_IDLE
                          : (cnt_r < CntW'(2)) ? S_IDLE : S_OP_RD2;
      S_OP_RD2: state_nxt = S_OP_WAIT;
      S_OP_WAIT: state_nxt = S_OP_START;
      S_OP_START: state_nxt = (ch_r == ChPlus || ch_r == ChMinus) ? S_OP_PUSH
                            : (ch_r == ChSlash && right_r == '0) ? S_IDLE : S_OP_RUN;
      S_OP_RUN: if (udone) state_nxt = S_OP_PUSH;
      S_OP_PUSH: state_nxt = S_IDLE;
      S_END_RD: state_nxt = S_END_WAIT;
      S_END_WAIT: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sum = '0;
    res = '0;
    mag = '0;
    over = 1'b0;
    frac = '0;
    unique case (ch_r)
      ChPlus: begin
        sum = left_r + right_r;
        res = (left_r[63] == right_r[63] && sum[63] != left_r[63])
              ? (left_r[63] ? NegMax : PosMax) : sum;
      end
      ChMinus: begin
        sum = left_r - right_r;
        res = (left_r[63] != right_r[63] && sum[63] != left_r[63])
              ? (left_r[63] ? NegMax : PosMax) : sum;
      end
      default: begin
        mag = uquo[63:0];
        over = uquo[95:64] != 32'd0;
        if (over || mag > (neg_r ? NegMax : PosMax)) res = neg_r ? NegMax : PosMax;
        else res = neg_r ? (~mag + 64'd1) : mag;
      end
    endcase
    frac = {32'd0, uquo[32:1]} + {63'd0, uquo[0]};
  end

  always_comb begin
    cnt_nxt = cnt_r; mant_nxt = mant_r; nchars_nxt = nchars_r;
    point_nxt = point_r; second_nxt = second_r; fdig_nxt = fdig_r; err_nxt = err_r;
    right_nxt = right_r; left_nxt = left_r; whole_nxt = whole_r; neg_nxt = neg_r;
    ovalid_nxt = ovalid_r; oval_nxt = oval_r; ostat_nxt = ostat_r;
    wr_en = 1'b0; wr_addr = cnt_r[SpW-1:0]; wr_data = '0;
    rd_addr = SpW'(cnt_r - CntW'(1));
    uctl = '{start: 1'b0, mode: MODE_DIV};
    ua = {mant_r[62:0], 1'b0}; ub = p10;
    if (out_acc) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && err_r == ST_OK && (is_digit || is_point)) begin
          nchars_nxt = nchars_r + NcW'(1);
          if (is_point) begin
            if (point_r) second_nxt = 1'b1;
            point_nxt = 1'b1;
          end else if (!second_r) begin
            mant_nxt = mant_r * 64'd10 + {56'd0, in_ch.char_code - ChZero};
            if (point_r) fdig_nxt = fdig_r + 5'd1;
          end
          if (nchars_r + NcW'(1) >= NcW'(MaxNumberChars)) begin
            err_nxt = ST_LONG;
            mant_nxt = '0; nchars_nxt = '0; point_nxt = 1'b0;
            second_nxt = 1'b0; fdig_nxt = '0;
          end
        end
        if (state_nxt == S_CONV_DIV) uctl = '{start: 1'b1, mode: MODE_DIV};
      end
      S_CONV_DIV: begin
        if (udone) whole_nxt = {1'b0, uquo[95:33]};
      end
      S_CONV_PUSH: begin
        mant_nxt = '0; nchars_nxt = '0; point_nxt = 1'b0; second_nxt = 1'b0; fdig_nxt = '0;
        if (cnt_r >= CntW'(StackDepth)) err_nxt = ST_OVER;
        else begin
          wr_en = 1'b1;
          if (whole_r > 64'h7FFF_FFFF) wr_data = PosMax;
          else wr_data = {whole_r[31:0], 32'd0} + frac;
          if (!(whole_r > 64'h7FFF_FFFF) && wr_data[63]) wr_data = PosMax;
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      S_OP_RD1: begin
        mant_nxt = '0; nchars_nxt = '0; point_nxt = 1'b0; second_nxt = 1'b0; fdig_nxt = '0;
        if (err_r == ST_OK && ch_r != 8'd0 && is_op && cnt_r < CntW'(2)) err_nxt = ST_UNDER;
      end
      S_OP_RD2: begin
        rd_addr = SpW'(cnt_r - CntW'(2));
        right_nxt = rd_r;
      end
      S_OP_WAIT: left_nxt = rd_r;
      S_OP_START: begin
        cnt_nxt = cnt_r - CntW'(2);
      end
      S_OP_RUN: ;
      S_OP_PUSH: begin
        wr_addr = cnt_r[SpW-1:0];
        wr_en = 1'b1;
        wr_data = res;
        cnt_nxt = cnt_r + CntW'(1);
      end
      S_END_RD: begin
        mant_nxt = '0; nchars_nxt = '0; point_nxt = 1'b0; second_nxt = 1'b0; fdig_nxt = '0;
      end
      S_OUT: begin
        ovalid_nxt = 1'b1;
        if (err_r == ST_OK && cnt_r == '0) begin
          ostat_nxt = ST_UNDER; oval_nxt = '0;
        end else if (err_r != ST_OK) begin
          ostat_nxt = err_r; oval_nxt = '0;
        end else begin
          ostat_nxt = ST_OK; oval_nxt = rd_r;
        end
        cnt_nxt = '0; err_nxt = ST_OK;
      end
      default: ;
    endcase
    // operator start uses left_r from stack read; * and / by nonzero launch unit next cycle
    if (state_r == S_OP_START) begin
      neg_nxt = left_r[63] ^ right_r[63];
      if (ch_r == ChSlash && right_r == '0) err_nxt = ST_DIV0;
    end
    if (state_r == S_OP_RUN && !ubusy && !udone && !uctl.start) begin
      uctl = '{start: 1'b1, mode: (ch_r == ChStar) ? MODE_MUL : MODE_DIV};
      ua = ma; ub = mb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; mant_r <= '0; nchars_r <= '0;
      point_r <= 1'b0; second_r <= 1'b0; fdig_r <= '0; err_r <= ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; mant_r <= mant_nxt; nchars_r <= nchars_nxt;
      point_r <= point_nxt; second_r <= second_nxt; fdig_r <= fdig_nxt; err_r <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
    if (in_acc) ch_r <= in_ch.char_code;
    right_r <= right_nxt; left_r <= left_nxt; whole_r <= whole_nxt; neg_r <= neg_nxt;
    oval_r <= oval_nxt; ostat_r <= ostat_nxt;
  end

  `RPN_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CntW'(StackDepth))
  `RPN_ASSERT_IMP(a_no_in_when_out, clk, rst_n, ovalid_r, !in_ch.ready)
  `RPN_ASSERT_IMP(a_out_err_zero, clk, rst_n, ovalid_r && ostat_r != ST_OK, oval_r == '0)
  `RPN_ASSERT_NEXT(a_out_clears, clk, rst_n, state_r == S_OUT, cnt_r == '0 && err_r == ST_OK)
endmodule
`default_nettype wire

// File: rtl/rpn_unit.sv
// Shared bit-serial unit: restoring divide and shift-add multiply
`default_nettype none
`include "rpn_expression_evaluator_defines.svh"
module rpn_unit
  import rpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire unit_ctl_t   ctl,
  input  wire logic [63:0] a_in,
  input  wire logic [63:0] b_in,
  output logic             busy,
  output logic             done,
  output logic [95:0]      quo
);
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [1:0]   mode_r, mode_nxt;
  logic [95:0]  acc_r, acc_nxt;
  logic [64:0]  rem_r, rem_nxt;
  logic [63:0]  b_r, b_nxt;
  logic [64:0]  trial;
  logic [127:0] prod_r, prod_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    b_nxt = b_r;
    prod_nxt = prod_r;
    trial = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      mode_nxt = ctl.mode;
      b_nxt = b_in;
      rem_nxt = '0;
      prod_nxt = '0;
      unique case (ctl.mode)
        MODE_DIV: begin acc_nxt = {a_in, 32'd0}; cnt_nxt = 7'd96; end
        MODE_MUL: begin acc_nxt = {32'd0, a_in}; cnt_nxt = 7'd64; end
        default: begin acc_nxt = '0; cnt_nxt = 7'd1; end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      unique case (mode_r)
        MODE_MUL: begin
          prod_nxt = acc_r[0] ? {({1'b0, prod_r[127:64]} + {1'b0, b_r}), prod_r[63:1]}
                              : {1'b0, prod_r[127:1]};
          acc_nxt = {1'b0, acc_r[95:1]};
        end
        default: begin
          trial = {rem_r[63:0], acc_r[95]};
          if (trial >= {1'b0, b_r}) begin
            rem_nxt = trial - {1'b0, b_r};
            acc_nxt = {acc_r[94:0], 1'b1};
          end else begin
            rem_nxt = trial;
            acc_nxt = {acc_r[94:0], 1'b0};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
      mode_r <= MODE_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
      mode_r <= mode_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    b_r <= b_nxt;
    prod_r <= prod_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo = (mode_r == MODE_MUL) ? prod_r[127:32] : acc_r;

  `RPN_ASSERT_NEXT(a_done_after_busy, clk, rst_n, busy_r && cnt_r == 7'd1 && !ctl.start, done_r)
  `RPN_ASSERT_IMP(a_no_start_busy, clk, rst_n, ctl.start, !busy_r)
  `RPN_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r || ctl.start)
endmodule
`default_nettype wire

// File: sim/rpn_scoreboard.sv
// Scoreboard class: postfix evaluator prediction and result checking
class rpn_scoreboard;
  typedef struct {
    logic [63:0] value;
    logic [2:0]  status;
  } rpn_result_t;

  logic [63:0]   stack_mem[rpn_pkg::StackDepth];
  int unsigned   depth_used;
  logic [63:0]   mantissa;
  int unsigned   nchars;
  bit            point_seen;
  int unsigned   frac_digits;
  bit            second_point;
  logic [2:0]    err_code;
  rpn_result_t   pending_results[$];
  int unsigned   fail_count;

  function new();
    fail_count = 0;
    clear_all();
  endfunction

  function void clear_number();
    mantissa = 0;
    nchars = 0;
    point_seen = 0;
    frac_digits = 0;
    second_point = 0;
  endfunction

  function void clear_all();
    depth_used = 0;
    err_code = rpn_pkg::ST_OK;
    clear_number();
  endfunction

  function void flag(logic [2:0] code);
    if (err_code == rpn_pkg::ST_OK) err_code = code;
  endfunction

  function logic [63:0] mag_of(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function logic [63:0] signed_sat(bit neg, logic [63:0] m, bit over);
    logic [63:0] lim;
    lim = neg ? rpn_pkg::NegMax : rpn_pkg::PosMax;
    if (over || m > lim) return neg ? rpn_pkg::NegMax : rpn_pkg::PosMax;
    return neg ? (~m + 64'd1) : m;
  endfunction

  function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? rpn_pkg::NegMax : rpn_pkg::PosMax;
    return s;
  endfunction

  function logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? rpn_pkg::NegMax : rpn_pkg::PosMax;
    return s;
  endfunction

  function logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
    return signed_sat(a[63] ^ b[63], p[95:32], p[127:96] != 0);
  endfunction

  function logic [63:0] div_sat(logic [63:0] a, logic [63:0] b);
    logic [95:0] q;
    q = {mag_of(a), 32'd0} / {32'd0, mag_of(b)};
    return signed_sat(a[63] ^ b[63], q[63:0], q[95:64] != 0);
  endfunction

  function logic [63:0] to_fixed();
    logic [63:0] p, whole, rem, frac, v;
    p = 64'd1;
    for (int i = 0; i < frac_digits && i < 16; i++) p = p * 64'd10;
    whole = mantissa / p;
    rem = mantissa % p;
    frac = 0;
    if (whole > 64'h7FFF_FFFF) return rpn_pkg::PosMax;
    for (int i = 0; i < 33; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= p) begin
        rem = rem - p;
        frac[0] = 1'b1;
      end
    end
    frac = (frac + 64'd1) >> 1;
    v = (whole << 32) + frac;
    return (v > rpn_pkg::PosMax) ? rpn_pkg::PosMax : v;
  endfunction

  function void push(logic [63:0] v);
    if (depth_used >= rpn_pkg::StackDepth) begin
      flag(rpn_pkg::ST_OVER);
      return;
    end
    stack_mem[depth_used] = v;
    depth_used++;
  endfunction

  function void close_number();
    if (nchars != 0 && err_code == rpn_pkg::ST_OK) push(to_fixed());
    clear_number();
  endfunction

  function void note_char(logic [7:0] c);
    rpn_result_t r;
    logic [63:0] rt, lt, res;
    if (c == 8'd0) begin
      close_number();
      if (err_code == rpn_pkg::ST_OK && depth_used == 0) flag(rpn_pkg::ST_UNDER);
      r.value = (err_code == rpn_pkg::ST_OK) ? stack_mem[depth_used - 1] : 64'd0;
      r.status = err_code;
      pending_results.push_back(r);
      clear_all();
      return;
    end
    if (err_code != rpn_pkg::ST_OK) return;
    if ((c >= rpn_pkg::ChZero && c <= rpn_pkg::ChNine) || c == rpn_pkg::ChPoint) begin
      nchars++;
      if (c == rpn_pkg::ChPoint) begin
        if (point_seen) second_point = 1;
        point_seen = 1;
      end else if (!second_point) begin
        mantissa = mantissa * 64'd10 + 64'(c - rpn_pkg::ChZero);
        if (point_seen) frac_digits++;
      end
      if (nchars >= rpn_pkg::MaxNumberChars) begin
        flag(rpn_pkg::ST_LONG);
        clear_number();
      end
      return;
    end
    close_number();
    if (err_code != rpn_pkg::ST_OK) return;
    if (c == rpn_pkg::ChPlus || c == rpn_pkg::ChMinus || c == rpn_pkg::ChStar ||
        c == rpn_pkg::ChSlash) begin
      if (depth_used < 2) begin
        flag(rpn_pkg::ST_UNDER);
        return;
      end
      rt = stack_mem[depth_used - 1];
      lt = stack_mem[depth_used - 2];
      depth_used -= 2;
      if (c == rpn_pkg::ChPlus) res = add_sat(lt, rt);
      else if (c == rpn_pkg::ChMinus) res = sub_sat(lt, rt);
      else if (c == rpn_pkg::ChStar) res = mul_sat(lt, rt);
      else begin
        if (rt == 0) begin
          flag(rpn_pkg::ST_DIV0);
          return;
        end
        res = div_sat(lt, rt);
      end
      push(res);
    end
  endfunction

  function void check_result(logic [63:0] value, logic [2:0] status);
    rpn_result_t r;
    if (pending_results.size() == 0) begin
      $error("unexpected result value=%h status=%0d", value, status);
      fail_count++;
      return;
    end
    r = pending_results.pop_front();
    if (value !== r.value) begin
      $error("value expected %h actual %h", r.value, value);
      fail_count++;
    end
    if (status !== r.status) begin
      $error("status expected %0d actual %0d", r.status, status);
      fail_count++;
    end
  endfunction
endclass

// File: sim/testbench.sv
// Testbench top: drives character beats, checks results through the scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 49;
  bit hold_off = 0;
  rpn_scoreboard sb = new();

  rpn_char_if in_ch (clk);
  rpn_result_if out_ch (clk);

  rpn_expression_evaluator dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.char_code = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.value, out_ch.status);
    out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_char(logic [7:0] c);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.char_code <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_char(c);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i]);
    send_char(8'd0);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(ChZero + $urandom_range(9));
  endfunction

  task automatic send_number();
    int n;
    n = $urandom_range(4) == 0 ? $urandom_range(12, 1) : $urandom_range(5, 1);
    for (int i = 0; i < n; i++)
      send_char($urandom_range(7) == 0 ? ChPoint : rand_digit());
  endtask

  function automatic logic [7:0] rand_op();
    case ($urandom_range(3))
      0: return ChPlus;
      1: return ChMinus;
      2: return ChStar;
      default: return ChSlash;
    endcase
  endfunction

  task automatic send_expression();
    int depth, ops;
    depth = 0;
    ops = $urandom_range(6, 1);
    send_number();
    depth++;
    while (ops > 0) begin
      if ($urandom_range(9) == 0) send_char(8'($urandom_range(255, 1)));
      if (depth >= 2 && $urandom_range(1)) begin
        send_char(rand_op());
        depth--;
        ops--;
      end else begin
        send_char(8'h20);
        send_number();
        depth++;
      end
    end
    send_char(8'd0);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_text("3 4+");
    send_text("9.5 2-");
    send_text("2147483647 2147483647*");
    send_text("1 3/");
    send_text("5 0/");
    send_text("123456789012");
    send_text("1+");
    send_text("");
    send_text("1.2.3 .");
    send_text("0.0000000005");
    send_text("7 8 9 ");
    send_char(8'hFF);
    send_char(8'h00);
    for (int i = 0; i < 33; i++) begin
      send_char(8'h31);
      send_char(8'h20);
    end
    send_char(8'd0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 22 : ph == 1 ? 49 : 0;
      recv_idle_pct = ph == 0 ? 49 : ph == 1 ? 22 : 0;
      for (int k = 0; k < 22; k++) begin
        if ($urandom_range(5) == 0) begin
          for (int j = 0; j < 6; j++) send_char(8'($urandom_range(255, 1)));
          send_char(8'd0);
        end else send_expression();
        if (ph == 2 && k == 10) hold_off = 1;
      end
    end
    in_ch.valid <= 0;
    drain();
    if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int unsigned held;
    wait (hold_off);
    held = 0;
    while (held < 3000) begin
      @(posedge clk);
      held++;
    end
    hold_off = 0;
  end
endmodule
